@@ design/b64d_pkg.sv @@
// Package with the item types, group type and character mapping of the base64 decoder.
`timescale 1ns / 1ps

package b64d_pkg;

    localparam logic [6:0] PAD_CODE = 7'd64;

    typedef struct packed {
        logic [7:0] in_char;
        logic       final_char;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_group;
    } out_item_t;

    // One closed group: its three candidate bytes and how many of them are emitted (1..3).
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] count;
    } group_t;

    // Maps one text character to its 6-bit code; everything outside the alphabet is pad.
    function automatic logic [6:0] char_to_code(input logic [7:0] ch);
        logic [6:0] code;
        code = PAD_CODE;
        if (ch >= 8'h41 && ch <= 8'h5A)
            code = 7'(ch - 8'd65);
        else if (ch >= 8'h61 && ch <= 8'h7A)
            code = 7'(ch - 8'd71);
        else if (ch >= 8'h30 && ch <= 8'h39)
            code = 7'(ch + 8'd4);
        else if (ch == 8'h2B)
            code = 7'd62;
        else if (ch == 8'h2F)
            code = 7'd63;
        return code;
    endfunction

endpackage

@@ design/b64d_front.sv @@
// Front end of the base64 decoder: maps characters to codes and assembles closed groups.
`timescale 1ns / 1ps

module b64d_front
    import b64d_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  in_item_t in_data,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     queue_full,
    output logic     push_valid,
    output group_t   push_group
);

    logic [6:0] held_codes_reg [3];
    logic [6:0] held_codes_next [3];
    logic [1:0] codes_held_reg;
    logic [1:0] codes_held_next;
    logic [6:0] code;
    logic [6:0] c [4];
    logic       accept;
    logic       closes;
    logic [1:0] count;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign code     = char_to_code(in_data.in_char);
    assign closes   = in_data.final_char || (codes_held_reg == 2'd3);

    // Codes of the group being closed; slots past the new code are pad.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (k < int'(codes_held_reg))
                c[k] = held_codes_reg[k];
            else if (k == int'(codes_held_reg))
                c[k] = code;
            else
                c[k] = PAD_CODE;
        end
    end

    always_comb
    begin
        if (c[0] == PAD_CODE)
            count = 2'd0;
        else if (c[2] == PAD_CODE)
            count = 2'd1;
        else if (c[3] == PAD_CODE)
            count = 2'd2;
        else
            count = 2'd3;
    end

    // Pad codes enter the byte arithmetic with their value of 64.
    assign push_group.byte0 = {c[0][5:0], 2'b00} | {5'b00000, c[1][6:4]};
    assign push_group.byte1 = {c[1][3:0], 4'b0000} | {3'b000, c[2][6:2]};
    assign push_group.byte2 = {c[2][1:0], 6'b000000} | {1'b0, c[3]};
    assign push_group.count = count;
    assign push_valid       = accept && closes && (count != 2'd0);

    always_comb
    begin
        held_codes_next = held_codes_reg;
        codes_held_next = codes_held_reg;
        if (accept)
        begin
            if (closes)
                codes_held_next = 2'd0;
            else
            begin
                held_codes_next[codes_held_reg] = code;
                codes_held_next = codes_held_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_held_reg <= 2'd0;
            for (int k = 0; k < 3; k++)
                held_codes_reg[k] <= 7'd0;
        end
        else
        begin
            codes_held_reg <= codes_held_next;
            held_codes_reg <= held_codes_next;
        end
    end

endmodule

@@ design/b64d_queue.sv @@
// Short group queue between the front end and the byte sequencer.
`timescale 1ns / 1ps

module b64d_queue
    import b64d_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    input  group_t push_group,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output group_t head_group
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    group_t           entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_group = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_group;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ design/b64d_back.sv @@
// Back end of the base64 decoder: emits the bytes of each queued group one per cycle while out_ready is high.
`timescale 1ns / 1ps

module b64d_back
    import b64d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  group_t    head_group,
    output logic      pop,
    output out_item_t out_data,
    output logic      out_valid,
    input  logic      out_ready
);

    logic [1:0] index_reg;
    logic [1:0] index_next;
    logic       is_last;
    logic       accept;

    assign out_valid = head_valid;
    assign accept    = out_valid && out_ready;
    assign is_last   = (index_reg == head_group.count - 2'd1);
    assign pop       = accept && is_last;

    always_comb
    begin
        case (index_reg)
            2'd0:    out_data.out_byte = head_group.byte0;
            2'd1:    out_data.out_byte = head_group.byte1;
            default: out_data.out_byte = head_group.byte2;
        endcase
    end

    assign out_data.last_of_group = is_last;

    always_comb
    begin
        index_next = index_reg;
        if (accept)
            index_next = is_last ? 2'd0 : index_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            index_reg <= 2'd0;
        else
            index_reg <= index_next;
    end

endmodule

@@ design/base64_decoder.sv @@
// Top level of the streaming base64 decoder.
// Throughput: one character is accepted every cycle while the group queue has room.
// A closed group is registered in the queue before its first byte is offered, behind any earlier groups.
// A group emits one byte per cycle while out_ready is high, so a three-byte group holds the single output
// lane until all three bytes are taken; the queue absorbs the difference between input and output rates.
// Reset (rst_n, asynchronous, active low) empties the queue and clears the held-code count.
`timescale 1ns / 1ps

module base64_decoder
    import b64d_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_data,
    input  logic      in_valid,
    output logic      in_ready,
    output out_item_t out_data,
    output logic      out_valid,
    input  logic      out_ready
);

    // The front end maps each character to its code and closes a group on the fourth code or on
    // the final character. Only groups that emit at least one byte are pushed.
    logic   push_valid;
    group_t push_group;
    logic   queue_full;

    // The back end walks the head group byte by byte and pops it with its last byte.
    logic   pop;
    logic   head_valid;
    group_t head_group;

    b64d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_data    (in_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_group (push_group)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_group (push_group),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_group (head_group)
    );

    b64d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_group (head_group),
        .pop        (pop),
        .out_data   (out_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the streaming base64 decoder.
`timescale 1ns / 1ps

module tb_top;
    import b64d_pkg::*;

    localparam int  HALF_PERIOD  = 5;
    localparam int  RESET_CYCLES = 8;
    localparam int  RANDOM_ITEMS = 350;
    // The no-idle stretch at the end of the run starts once this many characters are left.
    localparam int  CALM_ITEMS   = 40;
    localparam int  DRAIN_CYCLES = 20;
    localparam int  CYCLE_LIMIT  = 200000;
    localparam logic [6:0] PAD   = 7'd64;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    in_item_t  in_data = '0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    out_item_t out_data;
    logic      out_valid;
    logic      out_ready = 1'b0;

    // Characters waiting to be sent, and decoded bytes waiting to come out.
    in_item_t  char_queue[$];
    out_item_t expected_bytes[$];

    // Codes of the group still open in the predictor.
    logic [6:0] open_codes[3];
    int         open_count = 0;

    int fail_count = 0;
    int cycle_count = 0;
    int send_gap = 0;
    int recv_stall = 0;

    base64_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    always #HALF_PERIOD clk = ~clk;

    // Maps a character to its 6-bit code; anything outside the alphabet decodes as pad.
    function automatic logic [6:0] code_of(input logic [7:0] ch);
        if (ch >= "A" && ch <= "Z")
            return 7'(ch - 8'd65);
        if (ch >= "a" && ch <= "z")
            return 7'(ch - 8'd71);
        if (ch >= "0" && ch <= "9")
            return 7'(ch + 8'd4);
        if (ch == "+")
            return 7'd62;
        if (ch == "/")
            return 7'd63;
        return PAD;
    endfunction

    // The inverse direction: picks the alphabet character for a 6-bit value.
    function automatic logic [7:0] alphabet_char(input int unsigned v);
        if (v < 26)
            return 8'("A" + v);
        if (v < 52)
            return 8'("a" + v - 26);
        if (v < 62)
            return 8'("0" + v - 52);
        if (v == 62)
            return "+";
        return "/";
    endfunction

    // Tracks the open group and, when a character closes it, queues the bytes that the
    // group yields. Pad codes enter the byte arithmetic with their value of 64, so a pad
    // in the middle of a group still shapes the bytes around it.
    task automatic decode_char(input in_item_t item);
        logic [6:0]  code;
        int unsigned c[4];
        int unsigned b[3];
        int          n;
        out_item_t   res;
        code = code_of(item.in_char);
        if (!item.final_char && open_count < 3) begin
            open_codes[open_count] = code;
            open_count++;
            return;
        end
        for (int k = 0; k < 4; k++)
            c[k] = PAD;
        for (int k = 0; k < open_count; k++)
            c[k] = open_codes[k];
        c[open_count] = code;
        open_count = 0;
        if (c[0] == PAD)
            n = 0;
        else if (c[2] == PAD)
            n = 1;
        else if (c[3] == PAD)
            n = 2;
        else
            n = 3;
        b[0] = ((c[0] << 2) | (c[1] >> 4)) & 32'hFF;
        b[1] = (((c[1] & 32'h0F) << 4) | (c[2] >> 2)) & 32'hFF;
        b[2] = (((c[2] & 32'h03) << 6) | c[3]) & 32'hFF;
        for (int k = 0; k < n; k++) begin
            res.out_byte      = b[k][7:0];
            res.last_of_group = (k == n - 1);
            expected_bytes.push_back(res);
        end
    endtask

    task automatic push_char(input logic [7:0] ch, input logic fin);
        in_item_t item;
        item.in_char    = ch;
        item.final_char = fin;
        char_queue.push_back(item);
    endtask

    task automatic push_text(input string s, input logic fin_on_last);
        for (int k = 0; k < s.len(); k++)
            push_char(s[k], fin_on_last && (k == s.len() - 1));
    endtask

    // Pushes one alphabet character, or now and then an arbitrary byte to break the group.
    task automatic push_group_char(input logic fin);
        if ($urandom_range(0, 9) == 0)
            push_char(8'($urandom_range(0, 255)), fin);
        else
            push_char(alphabet_char($urandom_range(0, 63)), fin);
    endtask

    // One encoded message: some full groups, then a tail that ends with the final flag.
    // Tails cover full groups, both padded forms, unpadded short groups and a lone character.
    task automatic push_message();
        int groups;
        int tail;
        groups = $urandom_range(0, 3);
        tail   = $urandom_range(0, 5);
        for (int g = 0; g < groups; g++)
            for (int k = 0; k < 4; k++)
                push_group_char(1'b0);
        case (tail)
            0: begin
                for (int k = 0; k < 3; k++)
                    push_group_char(1'b0);
                push_group_char(1'b1);
            end
            1: begin
                push_group_char(1'b0);
                push_group_char(1'b0);
                push_text("==", 1'b1);
            end
            2: begin
                for (int k = 0; k < 3; k++)
                    push_group_char(1'b0);
                push_text("=", 1'b1);
            end
            3: begin
                push_group_char(1'b0);
                push_group_char(1'b1);
            end
            4: begin
                push_group_char(1'b0);
                push_group_char(1'b0);
                push_group_char(1'b1);
            end
            default: push_group_char(1'b1);
        endcase
    endtask

    // Driver: presents the queued characters one item at a time and feeds each accepted
    // item to the predictor. Random idle bursts stop once the queue is nearly drained.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap <= 0;
        end
        else begin
            if (in_valid && in_ready)
                decode_char(in_data);
            if (in_valid && !in_ready) begin
                // Hold the item until it is taken.
            end
            else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (char_queue.size() > 0) begin
                if (char_queue.size() > CALM_ITEMS && $urandom_range(0, 7) == 0) begin
                    send_gap <= $urandom_range(0, 10);
                    in_valid <= 1'b0;
                end
                else begin
                    in_data  <= char_queue.pop_front();
                    in_valid <= 1'b1;
                end
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted byte against the oldest expectation and stalls the
    // output side in random bursts until at most CALM_ITEMS characters are left to send.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready  <= 1'b0;
            recv_stall <= 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected byte %0h, nothing was pending", out_data.out_byte);
                    fail_count++;
                end
                else begin
                    out_item_t want;
                    want = expected_bytes.pop_front();
                    if (out_data.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0h, got %0h",
                               want.out_byte, out_data.out_byte);
                        fail_count++;
                    end
                    if (out_data.last_of_group !== want.last_of_group) begin
                        $error("last_of_group: expected %0b, got %0b",
                               want.last_of_group, out_data.last_of_group);
                        fail_count++;
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                out_ready  <= 1'b0;
            end
            else if (char_queue.size() > CALM_ITEMS && $urandom_range(0, 7) == 0) begin
                recv_stall <= $urandom_range(0, 10);
                out_ready  <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog for a block that stops accepting or stops producing.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("base64_decoder test failed");
            $finish;
        end
    end

    initial begin
        // Directed part. A full group closes on its fourth character without the flag.
        push_text("TWFu", 1'b0);
        // Padded tails with one and two bytes.
        push_text("TQ==", 1'b1);
        push_text("TWE=", 1'b1);
        // A lone out-of-alphabet character flagged final: a group led by pad gives nothing.
        push_char(8'h00, 1'b1);
        // Top of the alphabet, then a short group closed by the flag after two codes.
        push_text("/+90", 1'b0);
        push_text("az", 1'b1);
        // A single final character at the start of a group.
        push_text("Z", 1'b1);
        // Pad in the second slot does not end the group.
        push_text("A=B9", 1'b0);
        // All-ones byte leading a group: four characters and no result.
        push_char(8'hFF, 1'b0);
        push_text("AAA", 1'b0);
        // Flag on the third code.
        push_text("9Az", 1'b1);

        while (char_queue.size() < RANDOM_ITEMS + 26) begin
            if ($urandom_range(0, 6) == 0)
                push_char(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
            else
                push_message();
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (char_queue.size() > 0 || in_valid)
            @(posedge clk);
        while (expected_bytes.size() > 0)
            @(posedge clk);
        // A group led by pad produces nothing, so give the block time to settle and
        // catch any stray output.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_bytes.size() == 0)
            $display("base64_decoder test passed");
        else
            $display("base64_decoder test failed");
        $finish;
    end

endmodule

@@ files.f @@
design/b64d_pkg.sv
design/b64d_front.sv
design/b64d_queue.sv
design/b64d_back.sv
design/base64_decoder.sv
tb/sv/tb_top.sv
